@@ hw/rtl/qtd_pkg.sv @@
// ----------------------------------------------------------------------------
// qtd_pkg
// Shared types and codes for the quadtree region decoder.
// ----------------------------------------------------------------------------
package qtd_pkg;

    localparam int QTD_MAX_LOG = 8;
    localparam int COORD_W     = 8;
    localparam int LOG_W       = 4;
    localparam int SYM_W       = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [LOG_W-1:0] SIZE_LOG_RST = LOG_W'(4);

    // tree symbols
    localparam logic [SYM_W-1:0] SYM_WHITE  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_BLACK  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_SPLIT  = 2'd2;
    localparam logic [SYM_W-1:0] SYM_UNUSED = 2'd3;

    // quadrant code with both right and lower set: last child of a split
    localparam logic [1:0] QUAD_LAST = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP     = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] region_x;
        logic [COORD_W-1:0] region_y;
        logic [LOG_W-1:0]   region_log;
        logic               colour;
        logic               is_error;
        logic               tree_done;
    } t_region;

endpackage

@@ hw/rtl/qtd_locate.sv @@
// ----------------------------------------------------------------------------
// qtd_locate
// Builds the corner coordinates of a node from its quadrant path.
// ----------------------------------------------------------------------------
module qtd_locate
    import qtd_pkg::*;
#(
    parameter int MAX_LOG = QTD_MAX_LOG
) (
    input  logic [1:0]         i_path [MAX_LOG],
    input  logic [LOG_W-1:0]   i_eff_log,
    input  logic [LOG_W-1:0]   i_levels,
    input  logic               i_flip,
    output logic [COORD_W-1:0] o_x,
    output logic [COORD_W-1:0] o_y
);

    // level i of the path lands on bit eff_log-1-i of each coordinate
    always_comb begin
        o_x = '0;
        o_y = '0;
        for (int b = 0; b < COORD_W; b++) begin
            for (int i = 0; i < MAX_LOG; i++) begin
                if ((i + b + 1 <= MAX_LOG) && (LOG_W'(i + b + 1) == i_eff_log)
                        && (LOG_W'(i) < i_levels)) begin
                    o_x[b] = i_path[i][0];
                    o_y[b] = i_path[i][1] ^ i_flip;
                end
            end
        end
    end

endmodule

@@ hw/rtl/qtd_walk.sv @@
// ----------------------------------------------------------------------------
// qtd_walk
// Tree walk state (depth, quadrant path) and the per-symbol step.
// ----------------------------------------------------------------------------
module qtd_walk
    import qtd_pkg::*;
#(
    parameter int MAX_LOG = QTD_MAX_LOG
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic [LOG_W-1:0] i_size_log,
    input  logic             i_flip,
    output logic             o_res_valid,
    output t_region          o_res
);

    localparam int DEPTH_W = $clog2(MAX_LOG + 1);
    localparam int IDX_W   = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;

    logic               r_active;
    logic [DEPTH_W-1:0] r_depth;
    logic [1:0]         r_path [MAX_LOG];

    logic               n_active;
    logic [DEPTH_W-1:0] n_depth;
    logic [1:0]         n_path [MAX_LOG];

    logic [LOG_W-1:0]   eff_log;
    logic [DEPTH_W-1:0] d;
    logic [LOG_W-1:0]   levels;
    logic               deep;
    logic [1:0]         path_cur [MAX_LOG];
    logic               found;
    logic [IDX_W-1:0]   jsel;
    logic [COORD_W-1:0] loc_x;
    logic [COORD_W-1:0] loc_y;

    assign eff_log = (i_size_log > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : i_size_log;
    // no tree in progress: start at the root with a clear path
    assign d       = r_active ? r_depth : '0;
    assign deep    = LOG_W'(d) >= eff_log;
    assign levels  = deep ? eff_log : LOG_W'(d);

    always_comb begin
        for (int k = 0; k < MAX_LOG; k++) begin
            path_cur[k] = r_active ? r_path[k] : 2'd0;
        end
    end

    // deepest level above the node that still has a sibling left
    always_comb begin
        found = 1'b0;
        jsel  = '0;
        for (int j = 0; j < MAX_LOG; j++) begin
            if ((DEPTH_W'(j) < d) && (path_cur[j] != QUAD_LAST)) begin
                found = 1'b1;
                jsel  = IDX_W'(j);
            end
        end
    end

    qtd_locate #(
        .MAX_LOG (MAX_LOG)
    ) u_locate (
        .i_path    (path_cur),
        .i_eff_log (eff_log),
        .i_levels  (levels),
        .i_flip    (i_flip),
        .o_x       (loc_x),
        .o_y       (loc_y)
    );

    always_comb begin
        n_active          = r_active;
        n_depth           = r_depth;
        n_path            = r_path;
        o_res_valid       = 1'b0;
        o_res.region_x    = loc_x;
        o_res.region_y    = loc_y;
        o_res.region_log  = eff_log - levels;
        o_res.colour      = 1'b0;
        o_res.is_error    = 1'b0;
        o_res.tree_done   = 1'b0;
        if (i_fire) begin
            case (i_symbol) inside
                SYM_SPLIT: begin
                    if (deep) begin
                        o_res_valid      = 1'b1;
                        o_res.region_log = '0;
                        o_res.is_error   = 1'b1;
                        o_res.tree_done  = 1'b1;
                        n_active         = 1'b0;
                        n_depth          = '0;
                    end else begin
                        n_path = path_cur;
                        for (int k = 0; k < MAX_LOG; k++) begin
                            if (DEPTH_W'(k) == d) begin
                                n_path[k] = 2'd0;
                            end
                        end
                        n_active = 1'b1;
                        n_depth  = d + DEPTH_W'(1);
                    end
                end
                SYM_WHITE, SYM_BLACK: begin
                    o_res_valid  = 1'b1;
                    o_res.colour = i_symbol[0];
                    n_path       = path_cur;
                    if (found) begin
                        for (int k = 0; k < MAX_LOG; k++) begin
                            if (IDX_W'(k) == jsel) begin
                                n_path[k] = path_cur[k] + 2'd1;
                            end
                        end
                        n_active = 1'b1;
                        n_depth  = DEPTH_W'(jsel) + DEPTH_W'(1);
                    end else begin
                        o_res.tree_done = 1'b1;
                        n_active        = 1'b0;
                        n_depth         = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_depth  <= '0;
            for (int k = 0; k < MAX_LOG; k++) begin
                r_path[k] <= 2'd0;
            end
        end else begin
            r_active <= n_active;
            r_depth  <= n_depth;
            r_path   <= n_path;
        end
    end

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_LOG))
        else $error("walk depth beyond maximum level");

    a_split_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_symbol == SYM_SPLIT) && !deep
            |=> r_active && (r_depth == $past(d) + DEPTH_W'(1)))
        else $error("split did not descend one level");

    a_done_ends_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.tree_done |=> !r_active)
        else $error("tree still active after its last region");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_error
            |-> o_res.tree_done && !o_res.colour && (o_res.region_log == '0))
        else $error("error word malformed");

    a_unused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_symbol == SYM_UNUSED) |=> $stable(r_active) && $stable(r_depth))
        else $error("unused symbol changed walk state");

endmodule

@@ hw/rtl/quadtree_region_decoder.sv @@
// Flow: an accepted symbol waits in the input register until its walk step
//   runs; the region word it yields goes to the result register on the output.
// Throughput: one symbol per cycle unless the region receiver stalls; each
//   symbol's walk step (descend, or the priority encode over MAX_LOG path levels
//   to find the next sibling) settles between the input and result registers.
// Reset (synchronous, active low): no tree in progress, path cleared, both
//   registers and config back to size_log 4, flip off.
// ----------------------------------------------------------------------------
// quadtree_region_decoder
// Decodes a prefix-coded quadtree into filled square regions, one per leaf.
// ----------------------------------------------------------------------------
module quadtree_region_decoder
    import qtd_pkg::*;
#(
    parameter int MAX_LOG = QTD_MAX_LOG
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // symbol channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SYM_W-1:0]      i_symbol,
    // region channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_region_x,
    output logic [COORD_W-1:0]    o_region_y,
    output logic [LOG_W-1:0]      o_region_log,
    output logic                  o_colour,
    output logic                  o_is_error,
    output logic                  o_tree_done,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_size_log;
    logic [LOG_W-1:0] r_size;
    logic             r_flip;
    logic             r_s1_valid;
    logic [SYM_W-1:0] r_s1_sym;
    logic             r_out_valid;
    t_region          r_out;

    logic             in_accept;
    logic             step_fire;
    logic             res_valid;
    t_region          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log <= 1'b0;
            r_size     <= SIZE_LOG_RST;
            r_flip     <= 1'b0;
        end else begin
            r_size_log <= i_cfg_valid && (i_cfg_index == CFG_SIZE_LOG);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SIZE_LOG: r_size <= i_cfg_data;
                    CFG_FLIP:     r_flip <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // the step may run when the result register is empty or being drained
    assign step_fire  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !step_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (step_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sym <= i_symbol;
        end
    end

    qtd_walk #(
        .MAX_LOG (MAX_LOG)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (step_fire),
        .i_symbol    (r_s1_sym),
        .i_size_log  (r_size),
        .i_flip      (r_flip),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_region_x   = r_out.region_x;
    assign o_region_y   = r_out.region_y;
    assign o_region_log = r_out.region_log;
    assign o_colour     = r_out.colour;
    assign o_is_error   = r_out.is_error;
    assign o_tree_done  = r_out.tree_done;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_out_valid || !i_out_stall)
        else $error("pending region word overwritten");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with nothing held");

    a_step_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> step_fire && (r_s1_sym != SYM_UNUSED))
        else $error("region word without a symbol behind it");

    a_cfg_size_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_SIZE_LOG)
            |=> r_size_log && (r_size == $past(i_cfg_data)))
        else $error("size register write lost");

endmodule

@@ bench/tb_quadtree_region_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_quadtree_region_decoder
// Feeds prefix-coded quadtree symbols into the decoder and checks every region
// word against a behavioural decoder kept in step with the accepted symbols.
// Runs directed and random trees (some cut short by a split at pixel size) and
// stray symbols across size and flip settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_quadtree_region_decoder;
    import qtd_pkg::*;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [SYM_W-1:0]      i_symbol     = SYM_WHITE;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [COORD_W-1:0]    o_region_x;
    logic [COORD_W-1:0]    o_region_y;
    logic [LOG_W-1:0]      o_region_log;
    logic                  o_colour;
    logic                  o_is_error;
    logic                  o_tree_done;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_SIZE_LOG;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    quadtree_region_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_symbol     (i_symbol),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_region_x   (o_region_x),
        .o_region_y   (o_region_y),
        .o_region_log (o_region_log),
        .o_colour     (o_colour),
        .o_is_error   (o_is_error),
        .o_tree_done  (o_tree_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    // decoder state as the block should hold it
    logic [LOG_W-1:0] size_reg = SIZE_LOG_RST;
    logic             flip_reg = 1'b0;
    logic             tree_open = 1'b0;
    int unsigned      depth_now = 0;
    logic [1:0]       quad_trail [QTD_MAX_LOG];

    logic [SYM_W-1:0] queued_symbols [$];
    t_region          pending_regions [$];

    int unsigned n_queued  = 0;
    int unsigned n_taken   = 0;
    int unsigned n_made    = 0;
    int unsigned n_bad     = 0;
    int unsigned idle_pct  = 7;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    initial foreach (quad_trail[k]) quad_trail[k] = 2'd0;

    function automatic int unsigned side_log();
        return (size_reg > QTD_MAX_LOG) ? QTD_MAX_LOG : int'(size_reg);
    endfunction

    // one decode step: updates the walk and queues the region word it yields
    function automatic void decode_symbol(input logic [SYM_W-1:0] sym);
        int unsigned lg;
        int unsigned d;
        int unsigned lv;
        int unsigned k;
        int unsigned x;
        int unsigned y;
        t_region     r;
        if (sym == SYM_UNUSED) return;
        if (!tree_open) begin
            tree_open = 1'b1;
            depth_now = 0;
            foreach (quad_trail[j]) quad_trail[j] = 2'd0;
        end
        lg = side_log();
        d  = (depth_now > QTD_MAX_LOG) ? QTD_MAX_LOG : depth_now;
        lv = (d < lg) ? d : lg;
        x  = 0;
        y  = 0;
        for (k = 0; k < lv; k++) begin
            x |= int'(quad_trail[k][0]) << (lg - 1 - k);
            y |= int'(quad_trail[k][1] ^ flip_reg) << (lg - 1 - k);
        end
        r = '0;
        r.region_x   = x[COORD_W-1:0];
        r.region_y   = y[COORD_W-1:0];
        r.region_log = LOG_W'(lg - lv);
        if (sym == SYM_SPLIT) begin
            if (d >= lg) begin
                // split below pixel size kills the tree
                r.is_error  = 1'b1;
                r.tree_done = 1'b1;
                tree_open   = 1'b0;
                depth_now   = 0;
                pending_regions.insert(pending_regions.size(), r);
            end else begin
                quad_trail[d] = 2'd0;
                depth_now     = d + 1;
            end
            return;
        end
        r.colour = sym[0];
        // back up past every level whose last quadrant is now filled
        k = d;
        while (k > 0 && quad_trail[k-1] == QUAD_LAST) k--;
        if (k == 0) begin
            r.tree_done = 1'b1;
            tree_open   = 1'b0;
            depth_now   = 0;
        end else begin
            quad_trail[k-1] = quad_trail[k-1] + 2'd1;
            depth_now       = k;
        end
        pending_regions.insert(pending_regions.size(), r);
    endfunction

    function automatic bit log_fault();
        n_bad++;
        return n_bad <= 10;
    endfunction

    function automatic void push_sym(input logic [SYM_W-1:0] sym);
        queued_symbols.insert(queued_symbols.size(), sym);
        n_queued++;
        if (sym != SYM_UNUSED) n_made++;
    endfunction

    // w white, b black, s split, x unused code
    function automatic void push_code(input string s);
        for (int i = 0; i < s.len(); i++) begin
            case (s[i])
                "w": push_sym(SYM_WHITE);
                "b": push_sym(SYM_BLACK);
                "s": push_sym(SYM_SPLIT);
                default: push_sym(SYM_UNUSED);
            endcase
        end
    endfunction

    // one random tree in prefix order; stops early after a split at pixel size
    function automatic void grow_tree();
        int unsigned lim;
        int unsigned lvl;
        int unsigned to_go [0:QTD_MAX_LOG];
        lim       = side_log();
        lvl       = 0;
        to_go[0]  = 1;
        while (1) begin
            to_go[lvl]--;
            if ($urandom_range(99) < 3) push_sym(SYM_UNUSED);
            if (lvl >= lim) begin
                if ($urandom_range(99) < 6) begin
                    push_sym(SYM_SPLIT);
                    return;
                end
                push_sym(SYM_W'($urandom_range(1)));
            end else if ($urandom_range(99) < ((lvl == 0) ? 70 : 25)) begin
                push_sym(SYM_SPLIT);
                lvl++;
                to_go[lvl] = 4;
                continue;
            end else begin
                push_sym(SYM_W'($urandom_range(1)));
            end
            while (lvl > 0 && to_go[lvl] == 0) lvl--;
            if (to_go[lvl] == 0) return;
        end
    endfunction

    function automatic void random_items(input int unsigned n);
        int unsigned goal;
        goal = n_made + n;
        while (n_made < goal) begin
            if ($urandom_range(99) < 8) push_sym(SYM_W'($urandom_range(3)));
            else grow_tree();
        end
    endfunction

    task automatic drain();
        while (n_taken != n_queued || pending_regions.size() != 0) @(posedge i_clk);
        // a trailing split may still be settling inside
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SIZE_LOG) size_reg = data;
        else flip_reg = data[0];
    endtask

    task automatic set_config(input logic [LOG_W-1:0] sz, input logic flip);
        drain();
        write_reg(CFG_SIZE_LOG, sz);
        write_reg(CFG_FLIP, {3'($urandom_range(7)), flip});
    endtask

    // symbol sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (queued_symbols.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_symbol   <= queued_symbols.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // region receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_region got;
        t_region want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                decode_symbol(i_symbol);
                n_taken++;
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                got = {o_region_x, o_region_y, o_region_log,
                       o_colour, o_is_error, o_tree_done};
                if (pending_regions.size() == 0) begin
                    if (log_fault())
                        $display("unexpected word: x %0d y %0d log %0d c %0b e %0b d %0b",
                                 got.region_x, got.region_y, got.region_log,
                                 got.colour, got.is_error, got.tree_done);
                end else begin
                    want = pending_regions.pop_front();
                    if (got.region_x !== want.region_x || got.region_y !== want.region_y ||
                        got.region_log !== want.region_log || got.colour !== want.colour ||
                        got.is_error !== want.is_error ||
                        got.tree_done !== want.tree_done) begin
                        if (log_fault()) begin
                            $display("mismatch exp: x %0d y %0d log %0d c %0b e %0b d %0b",
                                     want.region_x, want.region_y, want.region_log,
                                     want.colour, want.is_error, want.tree_done);
                            $display("         got: x %0d y %0d log %0d c %0b e %0b d %0b",
                                     got.region_x, got.region_y, got.region_log,
                                     got.colour, got.is_error, got.tree_done);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int unsigned waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: lone leaves, ignored code, a full tree, split too deep
        push_code("wbx");
        push_code("swbxwsbwbw");
        push_code("sssss");

        // leave a tree open, then shrink the image under it
        set_config(4'd8, 1'b1);
        push_code("sss");
        set_config(4'd2, 1'b0);
        random_items(140);

        set_config(4'd0, 1'b1);
        push_code("wsb");
        random_items(100);

        // receiver holds off while the sender keeps pushing
        set_config(4'd8, 1'b1);
        random_items(150);
        hold_req++;

        set_config(4'd15, 1'b0);
        random_items(140);

        set_config(4'd1, 1'b1);
        random_items(130);

        // no idling on either side
        set_config(4'd8, 1'b0);
        idle_pct = 0;
        random_items(200);
        drain();
        idle_pct = 7;

        set_config(4'd3, 1'b1);
        random_items(140);

        set_config(4'd12, 1'b1);
        random_items(130);

        set_config(4'd5, 1'b0);
        random_items(140);

        waited = 0;
        while ((n_taken != n_queued || pending_regions.size() != 0) && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        n_bad += pending_regions.size();
        // symbols that never got in count against the run as well
        if (n_taken != n_queued) n_bad++;

        if (n_bad == 0) begin
            $display("tb_quadtree_region_decoder OK");
        end else begin
            $display("tb_quadtree_region_decoder NOT OK");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb_quadtree_region_decoder NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/qtd_pkg.sv
hw/rtl/qtd_locate.sv
hw/rtl/qtd_walk.sv
hw/rtl/quadtree_region_decoder.sv
bench/tb_quadtree_region_decoder.sv
